[sv/lik_pkg.sv]
// shared types, constants and tables for the leg inverse kinematics block
`timescale 1ns / 1ps
package lik_pkg;

    // default link lengths in mm
    localparam int unsigned HIP_LEN_MM_DEF   = 30;
    localparam int unsigned THIGH_LEN_MM_DEF = 60;
    localparam int unsigned SHIN_LEN_MM_DEF  = 110;

    // square root lanes
    localparam int SQA_ROOT_W = 16;
    localparam int SQB_ROOT_W = 30;
    localparam int SQB_IN_W   = 2 * SQB_ROOT_W;

    // angle accumulator, 1/4096 degree
    localparam int ANG_W        = 22;
    localparam int CORDIC_ITERS = 16;
    localparam int ACOS_IN_W    = 32;
    localparam int ATAN_IN_W    = 17;

    localparam logic signed [ANG_W-1:0] ATAN_TAB [CORDIC_ITERS] = '{
        22'sd184320, 22'sd108810, 22'sd57492, 22'sd29184,
        22'sd14649,  22'sd7331,   22'sd3667,  22'sd1833,
        22'sd917,    22'sd458,    22'sd229,   22'sd115,
        22'sd57,     22'sd29,     22'sd14,    22'sd7
    };

    // leg numbers
    localparam logic [2:0] LEG_0 = 3'd0;
    localparam logic [2:0] LEG_1 = 3'd1;
    localparam logic [2:0] LEG_2 = 3'd2;
    localparam logic [2:0] LEG_3 = 3'd3;
    localparam logic [2:0] LEG_4 = 3'd4;
    localparam logic [2:0] LEG_5 = 3'd5;

    // geometry carried alongside the joint radicands
    typedef struct packed {
        logic [2:0]         leg;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic signed [16:0] l0;
        logic signed [31:0] n1;
        logic signed [11:0] hip_trim;
        logic signed [11:0] thigh_trim;
        logic signed [11:0] shin_trim;
        logic               reach;
    } lik_geo_t;

    // per-item tag seen by the output stages
    typedef struct packed {
        logic               reach;
        logic [2:0]         leg;
        logic signed [11:0] hip_trim;
        logic signed [11:0] thigh_trim;
        logic signed [11:0] shin_trim;
    } lik_tag_t;

endpackage

[sv/lik_if.sv]
// request and result channel interfaces
`timescale 1ns / 1ps
interface lik_req_if;
    logic               valid;
    logic               ready;
    logic [2:0]         leg_index;
    logic signed [15:0] target_x;
    logic signed [15:0] target_y;
    logic signed [15:0] target_z;
    logic signed [11:0] hip_trim;
    logic signed [11:0] thigh_trim;
    logic signed [11:0] shin_trim;

    modport source (
        output valid, leg_index, target_x, target_y, target_z,
        output hip_trim, thigh_trim, shin_trim,
        input  ready
    );
    modport sink (
        input  valid, leg_index, target_x, target_y, target_z,
        input  hip_trim, thigh_trim, shin_trim,
        output ready
    );
endinterface

interface lik_rsp_if;
    logic        valid;
    logic        ready;
    logic [11:0] hip_pwm;
    logic [11:0] thigh_pwm;
    logic [11:0] shin_pwm;
    logic        reachable;

    modport source (
        output valid, hip_pwm, thigh_pwm, shin_pwm, reachable,
        input  ready
    );
    modport sink (
        input  valid, hip_pwm, thigh_pwm, shin_pwm, reachable,
        output ready
    );
endinterface

[sv/lik_isqrt.sv]
// pipelined integer square root, one result bit per stage, rounds down
`timescale 1ns / 1ps
module lik_isqrt #(
    parameter int ROOT_W = 16,
    parameter int SIDE_W = 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [2*ROOT_W-1:0]   radicand,
    input  logic [SIDE_W-1:0]     side_in,
    output logic                  out_valid,
    output logic [ROOT_W-1:0]     root,
    output logic [SIDE_W-1:0]     side_out
);
    import lik_pkg::*;

    localparam int IN_W = 2 * ROOT_W;

    logic              vld_reg  [ROOT_W];
    logic [IN_W-1:0]   rem_reg  [ROOT_W];
    logic [IN_W-1:0]   root_reg [ROOT_W];
    logic [SIDE_W-1:0] side_reg [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_step
        localparam logic [IN_W-1:0] BIT = IN_W'(1) << (2 * (ROOT_W - 1 - k));
        logic              v_in;
        logic [IN_W-1:0]   rem_in;
        logic [IN_W-1:0]   root_in;
        logic [SIDE_W-1:0] side_k;
        logic [IN_W-1:0]   trial;
        logic [IN_W-1:0]   rem_next;
        logic [IN_W-1:0]   root_next;

        if (k == 0) begin : g_first
            assign v_in    = in_valid;
            assign rem_in  = radicand;
            assign root_in = '0;
            assign side_k  = side_in;
        end
        else begin : g_rest
            assign v_in    = vld_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign side_k  = side_reg[k-1];
        end

        always_comb
        begin
            trial = root_in + BIT;
            if (rem_in >= trial)
            begin
                rem_next  = rem_in - trial;
                root_next = (root_in >> 1) + BIT;
            end
            else
            begin
                rem_next  = rem_in;
                root_next = root_in >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else if (en)
                vld_reg[k] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                side_reg[k] <= side_k;
            end
        end
    end

    assign out_valid = vld_reg[ROOT_W-1];
    assign root      = root_reg[ROOT_W-1][ROOT_W-1:0];
    assign side_out  = side_reg[ROOT_W-1];

endmodule

[sv/lik_cordic.sv]
// pipelined vectoring cordic, atan2(a, b) in 1/4096 degree
`timescale 1ns / 1ps
module lik_cordic #(
    parameter int IN_W   = 17,
    parameter int SIDE_W = 1
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  logic                           in_valid,
    input  logic signed [IN_W-1:0]         a,
    input  logic signed [IN_W-1:0]         b,
    input  logic [SIDE_W-1:0]              side_in,
    output logic                           out_valid,
    output logic signed [lik_pkg::ANG_W-1:0] angle,
    output logic [SIDE_W-1:0]              side_out
);
    import lik_pkg::*;

    localparam int W = IN_W + 11;
    localparam int N = CORDIC_ITERS + 1;
    localparam logic signed [ANG_W-1:0] ANG90 = ANG_W'(90 * 4096);

    logic                    vld_reg  [N];
    logic signed [W-1:0]     x_reg    [N];
    logic signed [W-1:0]     y_reg    [N];
    logic signed [ANG_W-1:0] ang_reg  [N];
    logic [SIDE_W-1:0]       side_reg [N];

    logic signed [W-1:0]     xs;
    logic signed [W-1:0]     ys;
    logic signed [W-1:0]     x0_next;
    logic signed [W-1:0]     y0_next;
    logic signed [ANG_W-1:0] ang0_next;

    // scale by 256 and fold the left half plane over by a quarter turn
    always_comb
    begin
        xs = W'(b) <<< 8;
        ys = W'(a) <<< 8;
        if (xs < 0)
        begin
            if (ys >= 0)
            begin
                x0_next   = ys;
                y0_next   = -xs;
                ang0_next = ANG90;
            end
            else
            begin
                x0_next   = -ys;
                y0_next   = xs;
                ang0_next = -ANG90;
            end
        end
        else
        begin
            x0_next   = xs;
            y0_next   = ys;
            ang0_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else if (en)
            vld_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= x0_next;
            y_reg[0]    <= y0_next;
            ang_reg[0]  <= ang0_next;
            side_reg[0] <= side_in;
        end
    end

    for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_iter
        logic signed [W-1:0]     dx;
        logic signed [W-1:0]     dy;
        logic signed [W-1:0]     x_next;
        logic signed [W-1:0]     y_next;
        logic signed [ANG_W-1:0] ang_next;

        always_comb
        begin
            dx = y_reg[i] >>> i;
            dy = x_reg[i] >>> i;
            if (y_reg[i] > 0)
            begin
                x_next   = x_reg[i] + dx;
                y_next   = y_reg[i] - dy;
                ang_next = ang_reg[i] + ATAN_TAB[i];
            end
            else if (y_reg[i] < 0)
            begin
                x_next   = x_reg[i] - dx;
                y_next   = y_reg[i] + dy;
                ang_next = ang_reg[i] - ATAN_TAB[i];
            end
            else
            begin
                x_next   = x_reg[i];
                y_next   = y_reg[i];
                ang_next = ang_reg[i];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[i+1] <= 1'b0;
            else if (en)
                vld_reg[i+1] <= vld_reg[i];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[i+1]    <= x_next;
                y_reg[i+1]    <= y_next;
                ang_reg[i+1]  <= ang_next;
                side_reg[i+1] <= side_reg[i];
            end
        end
    end

    assign out_valid = vld_reg[N-1];
    assign angle     = ang_reg[N-1];
    assign side_out  = side_reg[N-1];

endmodule

[sv/lik_front.sv]
// front end: hip-plane distance, reach test and law-of-cosines radicands
`timescale 1ns / 1ps
module lik_front #(
    parameter int unsigned HIP_LEN_MM   = lik_pkg::HIP_LEN_MM_DEF,
    parameter int unsigned THIGH_LEN_MM = lik_pkg::THIGH_LEN_MM_DEF,
    parameter int unsigned SHIN_LEN_MM  = lik_pkg::SHIN_LEN_MM_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    lik_req_if.sink                        req,
    output logic                           out_valid,
    output lik_pkg::lik_geo_t              geo,
    output logic signed [31:0]             n2,
    output logic [lik_pkg::SQB_IN_W-1:0]   rad_thigh,
    output logic [lik_pkg::SQB_IN_W-1:0]   rad_shin
);
    import lik_pkg::*;

    localparam int     HIP_C = int'(HIP_LEN_MM) * 16;
    localparam int     F_C   = int'(THIGH_LEN_MM) * 16;
    localparam int     T_C   = int'(SHIN_LEN_MM) * 16;
    localparam longint FF    = longint'(F_C) * F_C;
    localparam longint TT    = longint'(T_C) * T_C;
    localparam longint SS    = longint'(F_C + T_C) * (F_C + T_C);
    localparam longint DD    = longint'(T_C - F_C) * (T_C - F_C);
    localparam bit     D_NEG = (T_C < F_C);

    localparam logic signed [16:0] HIP_L = 17'(HIP_C);
    localparam logic [31:0]        SS32  = 32'(SS);
    localparam logic [31:0]        DD32  = 32'(DD);
    localparam logic signed [31:0] FF32  = 32'(FF);
    localparam logic signed [31:0] TT32  = 32'(TT);
    localparam logic signed [31:0] FT32  = 32'(FF + TT);
    localparam logic [29:0]        K1    = 30'(4 * FF);
    localparam logic [59:0]        K2    = 60'(4 * FF * TT);

    typedef struct packed {
        logic [2:0]         leg;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic [31:0]        z2;
        logic signed [11:0] ht;
        logic signed [11:0] tt;
        logic signed [11:0] st;
    } side_a_t;

    // s1: squares
    logic               s1_v_reg;
    logic [31:0]        s1_x2_reg, s1_y2_reg;
    side_a_t            s1_side_reg;
    logic signed [31:0] px, py, pz;
    side_a_t            s1_side_next;

    assign req.ready = en;

    always_comb
    begin
        px = req.target_x * req.target_x;
        py = req.target_y * req.target_y;
        pz = req.target_z * req.target_z;
        s1_side_next.leg = req.leg_index;
        s1_side_next.x   = req.target_x;
        s1_side_next.y   = req.target_y;
        s1_side_next.z   = req.target_z;
        s1_side_next.z2  = pz;
        s1_side_next.ht  = req.hip_trim;
        s1_side_next.tt  = req.thigh_trim;
        s1_side_next.st  = req.shin_trim;
    end

    // s2: planar sum
    logic        s2_v_reg;
    logic [31:0] s2_sum_reg;
    side_a_t     s2_side_reg;

    // square root of x^2 + y^2
    logic                  sqa_v;
    logic [SQA_ROOT_W-1:0] sqa_root;
    logic [$bits(side_a_t)-1:0] sqa_side_vec;
    side_a_t               sqa_side;

    // s3 .. s8
    logic               s3_v_reg, s4_v_reg, s5_v_reg, s6_v_reg, s7_v_reg, s8_v_reg;
    side_a_t            s3_side_reg, s4_side_reg, s5_side_reg;
    logic signed [16:0] s3_l0_reg, s4_l0_reg, s5_l0_reg;
    logic [31:0]        s4_l0sq_reg;
    logic [31:0]        s5_l3_reg;
    lik_geo_t           s6_geo_reg, s7_geo_reg, s8_geo_reg;
    logic signed [31:0] s6_n2_reg, s7_n2_reg, s8_n2_reg;
    logic [29:0]        s6_l3_reg;
    logic signed [63:0] s7_n1sq_reg, s7_n2sq_reg;
    logic [59:0]        s7_kl_reg;
    logic [SQB_IN_W-1:0] s8_r1_reg, s8_r2_reg;

    logic signed [16:0] l0_next;
    logic signed [33:0] l0sq_full;
    logic [31:0]        l3_next;
    lik_geo_t           geo6_next;
    logic signed [31:0] n2_next;
    logic signed [63:0] d1, d2;
    logic [SQB_IN_W-1:0] r1_next, r2_next;

    lik_isqrt #(
        .ROOT_W (SQA_ROOT_W),
        .SIDE_W ($bits(side_a_t))
    ) u_sqrt_plane (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s2_v_reg),
        .radicand  (s2_sum_reg),
        .side_in   (s2_side_reg),
        .out_valid (sqa_v),
        .root      (sqa_root),
        .side_out  (sqa_side_vec)
    );

    assign sqa_side = side_a_t'(sqa_side_vec);

    always_comb
    begin
        l0_next   = signed'({1'b0, sqa_root}) - HIP_L;
        l0sq_full = s3_l0_reg * s3_l0_reg;
        l3_next   = s4_l0sq_reg + s4_side_reg.z2;

        // reach test on the exact squared lengths
        geo6_next.leg        = s5_side_reg.leg;
        geo6_next.x          = s5_side_reg.x;
        geo6_next.y          = s5_side_reg.y;
        geo6_next.z          = s5_side_reg.z;
        geo6_next.l0         = s5_l0_reg;
        geo6_next.n1         = FF32 + signed'({2'b0, s5_l3_reg[29:0]}) - TT32;
        geo6_next.hip_trim   = s5_side_reg.ht;
        geo6_next.thigh_trim = s5_side_reg.tt;
        geo6_next.shin_trim  = s5_side_reg.st;
        geo6_next.reach      = (s5_l3_reg < SS32) && (D_NEG || (s5_l3_reg > DD32));
        n2_next              = FT32 - signed'({2'b0, s5_l3_reg[29:0]});

        // negative radicand reads as zero
        d1 = signed'({4'b0, s7_kl_reg}) - s7_n1sq_reg;
        d2 = signed'({4'b0, K2}) - s7_n2sq_reg;
        r1_next = (d1 < 0) ? '0 : d1[SQB_IN_W-1:0];
        r2_next = (d2 < 0) ? '0 : d2[SQB_IN_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            s4_v_reg <= 1'b0;
            s5_v_reg <= 1'b0;
            s6_v_reg <= 1'b0;
            s7_v_reg <= 1'b0;
            s8_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_v_reg <= req.valid;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= sqa_v;
            s4_v_reg <= s3_v_reg;
            s5_v_reg <= s4_v_reg;
            s6_v_reg <= s5_v_reg;
            s7_v_reg <= s6_v_reg;
            s8_v_reg <= s7_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_x2_reg   <= px;
            s1_y2_reg   <= py;
            s1_side_reg <= s1_side_next;

            s2_sum_reg  <= s1_x2_reg + s1_y2_reg;
            s2_side_reg <= s1_side_reg;

            s3_side_reg <= sqa_side;
            s3_l0_reg   <= l0_next;

            s4_side_reg <= s3_side_reg;
            s4_l0_reg   <= s3_l0_reg;
            s4_l0sq_reg <= l0sq_full[31:0];

            s5_side_reg <= s4_side_reg;
            s5_l0_reg   <= s4_l0_reg;
            s5_l3_reg   <= l3_next;

            s6_geo_reg  <= geo6_next;
            s6_n2_reg   <= n2_next;
            s6_l3_reg   <= s5_l3_reg[29:0];

            s7_geo_reg  <= s6_geo_reg;
            s7_n2_reg   <= s6_n2_reg;
            s7_n1sq_reg <= s6_geo_reg.n1 * s6_geo_reg.n1;
            s7_n2sq_reg <= s6_n2_reg * s6_n2_reg;
            s7_kl_reg   <= 60'(K1) * 60'(s6_l3_reg);

            s8_geo_reg  <= s7_geo_reg;
            s8_n2_reg   <= s7_n2_reg;
            s8_r1_reg   <= r1_next;
            s8_r2_reg   <= r2_next;
        end
    end

    assign out_valid = s8_v_reg;
    assign geo       = s8_geo_reg;
    assign n2        = s8_n2_reg;
    assign rad_thigh = s8_r1_reg;
    assign rad_shin  = s8_r2_reg;

endmodule

[sv/lik_back.sv]
// back end: angle sums, mount offsets, clamp and pwm scaling
`timescale 1ns / 1ps
module lik_back (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             en,
    input  logic                             in_valid,
    input  logic signed [lik_pkg::ANG_W-1:0] acos_thigh,
    input  logic signed [lik_pkg::ANG_W-1:0] atan_thigh,
    input  logic signed [lik_pkg::ANG_W-1:0] acos_shin,
    input  logic signed [lik_pkg::ANG_W-1:0] atan_hip,
    input  lik_pkg::lik_tag_t                tag,
    output logic                             out_valid,
    output logic [11:0]                      hip_pwm,
    output logic [11:0]                      thigh_pwm,
    output logic [11:0]                      shin_pwm,
    output logic                             reachable
);
    import lik_pkg::*;

    localparam logic signed [ANG_W:0]  ROUND_HALF = 128;
    localparam logic signed [15:0]     THIGH_BIAS = 16'sd1664;
    localparam logic signed [15:0]     SHIN_BIAS  = -16'sd368;
    localparam logic signed [15:0]     DEG45      = 16'sd720;
    localparam logic signed [15:0]     DEG90      = 16'sd1440;
    localparam logic signed [15:0]     DEG135     = 16'sd2160;
    localparam logic signed [15:0]     DEG225     = 16'sd3600;
    localparam logic signed [15:0]     DEG270     = 16'sd4320;
    localparam logic signed [15:0]     DEG315     = 16'sd5040;
    localparam logic signed [15:0]     CLAMP_MAX  = 16'sd2880;
    localparam logic [17:0]            PWM_NUM    = 18'd91;
    localparam logic [27:0]            DIV9_RECIP = 28'd14564;
    localparam logic [11:0]            PWM_LOW    = 12'd1138;

    function automatic logic [11:0] clamp_deg(input logic signed [15:0] a);
        logic [11:0] r;
        if (a < 0)
            r = '0;
        else if (a > CLAMP_MAX)
            r = CLAMP_MAX[11:0];
        else
            r = a[11:0];
        return r;
    endfunction

    // b1: round to 1/16 degree and add biases and trims
    logic               b1_v_reg, b1_reach_reg;
    logic [2:0]         b1_leg_reg;
    logic signed [15:0] b1_hip_reg, b1_thigh_reg, b1_shin_reg;
    logic signed [ANG_W:0] sum_t, sum_s, sum_h;
    logic signed [ANG_W:0] rt, rs, rh;

    always_comb
    begin
        sum_t = (ANG_W+1)'(acos_thigh) + (ANG_W+1)'(atan_thigh);
        sum_s = (ANG_W+1)'(acos_shin);
        sum_h = (ANG_W+1)'(atan_hip);
        rt = (sum_t + ROUND_HALF) >>> 8;
        rs = (sum_s + ROUND_HALF) >>> 8;
        rh = (sum_h + ROUND_HALF) >>> 8;
    end

    // b2: mount offset and clamp
    logic        b2_v_reg, b2_reach_reg, b2_drive_reg;
    logic [11:0] b2_h_reg, b2_t_reg, b2_s_reg;
    logic signed [15:0] hip_m;
    logic               leg_ok;

    always_comb
    begin
        leg_ok = 1'b1;
        case (b1_leg_reg)
            LEG_0: hip_m = b1_hip_reg + DEG45;
            LEG_1: hip_m = b1_hip_reg + DEG90;
            LEG_2: hip_m = b1_hip_reg + DEG135;
            LEG_3: hip_m = (b1_hip_reg < 0) ? b1_hip_reg + DEG225 : b1_hip_reg - DEG135;
            LEG_4: hip_m = (b1_hip_reg < 0) ? b1_hip_reg + DEG270 : b1_hip_reg - DEG90;
            LEG_5: hip_m = (b1_hip_reg < 0) ? b1_hip_reg + DEG315 : b1_hip_reg - DEG45;
            default:
            begin
                hip_m  = b1_hip_reg;
                leg_ok = 1'b0;
            end
        endcase
    end

    // b3: times 91, b4: divide by 144 as shift by 4 and reciprocal of 9
    logic        b3_v_reg, b3_reach_reg, b3_drive_reg;
    logic [17:0] b3_qh_reg, b3_qt_reg, b3_qs_reg;
    logic        b4_v_reg, b4_reach_reg, b4_drive_reg;
    logic [27:0] b4_ph_reg, b4_pt_reg, b4_ps_reg;
    logic        b5_v_reg, b5_reach_reg;
    logic [11:0] b5_h_reg, b5_t_reg, b5_s_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_v_reg <= 1'b0;
            b2_v_reg <= 1'b0;
            b3_v_reg <= 1'b0;
            b4_v_reg <= 1'b0;
            b5_v_reg <= 1'b0;
        end
        else if (en)
        begin
            b1_v_reg <= in_valid;
            b2_v_reg <= b1_v_reg;
            b3_v_reg <= b2_v_reg;
            b4_v_reg <= b3_v_reg;
            b5_v_reg <= b4_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b1_reach_reg <= tag.reach;
            b1_leg_reg   <= tag.leg;
            b1_thigh_reg <= 16'(rt) + THIGH_BIAS + 16'(tag.thigh_trim);
            b1_shin_reg  <= 16'(rs) + SHIN_BIAS + 16'(tag.shin_trim);
            b1_hip_reg   <= 16'(rh) + 16'(tag.hip_trim);

            b2_reach_reg <= b1_reach_reg;
            b2_drive_reg <= b1_reach_reg && leg_ok;
            b2_h_reg     <= clamp_deg(hip_m);
            b2_t_reg     <= clamp_deg(b1_thigh_reg);
            b2_s_reg     <= clamp_deg(b1_shin_reg);

            b3_reach_reg <= b2_reach_reg;
            b3_drive_reg <= b2_drive_reg;
            b3_qh_reg    <= 18'(b2_h_reg) * PWM_NUM;
            b3_qt_reg    <= 18'(b2_t_reg) * PWM_NUM;
            b3_qs_reg    <= 18'(b2_s_reg) * PWM_NUM;

            b4_reach_reg <= b3_reach_reg;
            b4_drive_reg <= b3_drive_reg;
            b4_ph_reg    <= 28'(b3_qh_reg[17:4]) * DIV9_RECIP;
            b4_pt_reg    <= 28'(b3_qt_reg[17:4]) * DIV9_RECIP;
            b4_ps_reg    <= 28'(b3_qs_reg[17:4]) * DIV9_RECIP;

            b5_reach_reg <= b4_reach_reg;
            b5_h_reg     <= b4_drive_reg ? PWM_LOW + 12'(b4_ph_reg[27:17]) : '0;
            b5_t_reg     <= b4_drive_reg ? PWM_LOW + 12'(b4_pt_reg[27:17]) : '0;
            b5_s_reg     <= b4_drive_reg ? PWM_LOW + 12'(b4_ps_reg[27:17]) : '0;
        end
    end

    assign out_valid = b5_v_reg;
    assign hip_pwm   = b5_h_reg;
    assign thigh_pwm = b5_t_reg;
    assign shin_pwm  = b5_s_reg;
    assign reachable = b5_reach_reg;

endmodule

[sv/leg_inverse_kinematics_servo.sv]
// top level: three-joint leg inverse kinematics to servo pwm counts
// one request per cycle sustained unless a waiting result stalls the pipeline
// front end 24 (planar square root 16), joint square roots 30, cordic 17, output 5
// the whole pipeline advances together; it stalls only while a result waits
// async active-low reset clears every valid bit; data registers are not reset
`timescale 1ns / 1ps
module leg_inverse_kinematics_servo #(
    parameter int unsigned HIP_LEN_MM   = lik_pkg::HIP_LEN_MM_DEF,
    parameter int unsigned THIGH_LEN_MM = lik_pkg::THIGH_LEN_MM_DEF,
    parameter int unsigned SHIN_LEN_MM  = lik_pkg::SHIN_LEN_MM_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    lik_req_if.sink    req,
    lik_rsp_if.source  rsp
);
    import lik_pkg::*;

    logic                 en;
    logic                 f_v;
    lik_geo_t             geo;
    logic signed [31:0]   n2;
    logic [SQB_IN_W-1:0]  rad_thigh, rad_shin;

    logic                  sqt_v, sqs_v;
    logic [SQB_ROOT_W-1:0] root_thigh, root_shin;
    logic [$bits(lik_geo_t)-1:0] geo_b_vec;
    lik_geo_t              geo_b;
    logic [31:0]           n2_b_vec;

    logic                  ct_v, cs_v, cz_v, ch_v;
    logic signed [ANG_W-1:0] acos_thigh, acos_shin, atan_thigh, atan_hip;
    logic [11:0]           ct_side, cs_side;
    logic [0:0]            cz_side;
    logic [14:0]           ch_side;
    lik_tag_t              tag;

    logic        b_v;
    logic [11:0] hip_pwm, thigh_pwm, shin_pwm;
    logic        reachable;

    assign en = !rsp.valid || rsp.ready;

    lik_front #(
        .HIP_LEN_MM   (HIP_LEN_MM),
        .THIGH_LEN_MM (THIGH_LEN_MM),
        .SHIN_LEN_MM  (SHIN_LEN_MM)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .req       (req),
        .out_valid (f_v),
        .geo       (geo),
        .n2        (n2),
        .rad_thigh (rad_thigh),
        .rad_shin  (rad_shin)
    );

    lik_isqrt #(
        .ROOT_W (SQB_ROOT_W),
        .SIDE_W ($bits(lik_geo_t))
    ) u_sqrt_thigh (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (f_v),
        .radicand  (rad_thigh),
        .side_in   (geo),
        .out_valid (sqt_v),
        .root      (root_thigh),
        .side_out  (geo_b_vec)
    );

    lik_isqrt #(
        .ROOT_W (SQB_ROOT_W),
        .SIDE_W (32)
    ) u_sqrt_shin (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (f_v),
        .radicand  (rad_shin),
        .side_in   (n2),
        .out_valid (sqs_v),
        .root      (root_shin),
        .side_out  (n2_b_vec)
    );

    assign geo_b = lik_geo_t'(geo_b_vec);

    // acos(n / d) as atan2(sqrt(d^2 - n^2), n)
    lik_cordic #(
        .IN_W   (ACOS_IN_W),
        .SIDE_W (12)
    ) u_acos_thigh (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sqt_v),
        .a         (signed'(ACOS_IN_W'(root_thigh))),
        .b         (geo_b.n1),
        .side_in   (geo_b.thigh_trim),
        .out_valid (ct_v),
        .angle     (acos_thigh),
        .side_out  (ct_side)
    );

    lik_cordic #(
        .IN_W   (ACOS_IN_W),
        .SIDE_W (12)
    ) u_acos_shin (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sqt_v),
        .a         (signed'(ACOS_IN_W'(root_shin))),
        .b         (signed'(n2_b_vec)),
        .side_in   (geo_b.shin_trim),
        .out_valid (cs_v),
        .angle     (acos_shin),
        .side_out  (cs_side)
    );

    lik_cordic #(
        .IN_W   (ATAN_IN_W),
        .SIDE_W (1)
    ) u_atan_thigh (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sqt_v),
        .a         (ATAN_IN_W'(geo_b.z)),
        .b         (geo_b.l0),
        .side_in   (geo_b.reach),
        .out_valid (cz_v),
        .angle     (atan_thigh),
        .side_out  (cz_side)
    );

    lik_cordic #(
        .IN_W   (ATAN_IN_W),
        .SIDE_W (15)
    ) u_atan_hip (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sqt_v),
        .a         (ATAN_IN_W'(geo_b.x)),
        .b         (ATAN_IN_W'(geo_b.y)),
        .side_in   ({geo_b.leg, geo_b.hip_trim}),
        .out_valid (ch_v),
        .angle     (atan_hip),
        .side_out  (ch_side)
    );

    always_comb
    begin
        tag.reach      = cz_side[0];
        tag.leg        = ch_side[14:12];
        tag.hip_trim   = ch_side[11:0];
        tag.thigh_trim = ct_side;
        tag.shin_trim  = cs_side;
    end

    lik_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (ct_v),
        .acos_thigh (acos_thigh),
        .atan_thigh (atan_thigh),
        .acos_shin  (acos_shin),
        .atan_hip   (atan_hip),
        .tag        (tag),
        .out_valid  (b_v),
        .hip_pwm    (hip_pwm),
        .thigh_pwm  (thigh_pwm),
        .shin_pwm   (shin_pwm),
        .reachable  (reachable)
    );

    assign rsp.valid     = b_v;
    assign rsp.hip_pwm   = hip_pwm;
    assign rsp.thigh_pwm = thigh_pwm;
    assign rsp.shin_pwm  = shin_pwm;
    assign rsp.reachable = reachable;

    // parallel lanes must stay in lockstep
    a_sqrt_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        sqt_v == sqs_v)
        else $error("square root lanes out of step");

    a_cordic_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        (ct_v == cs_v) && (ct_v == cz_v) && (ct_v == ch_v))
        else $error("cordic lanes out of step");

    a_unreach_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.reachable |->
            rsp.hip_pwm == '0 && rsp.thigh_pwm == '0 && rsp.shin_pwm == '0)
        else $error("unreachable target drove a servo");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(b_v))
        else $error("pipeline moved during a stall");

endmodule

[dv/tb_leg_inverse_kinematics_servo.sv]
// self-checking testbench for the leg inverse kinematics servo block
`timescale 1ns / 1ps
module tb_leg_inverse_kinematics_servo;
    import lik_pkg::*;

    localparam longint THIGH_Q4 = longint'(THIGH_LEN_MM_DEF) * 16;
    localparam longint SHIN_Q4  = longint'(SHIN_LEN_MM_DEF) * 16;
    localparam longint HIP_Q4   = longint'(HIP_LEN_MM_DEF) * 16;
    localparam int     PWM_MIN  = 1138;
    localparam int     PWM_MAX  = 2958;
    localparam int     CYCLE_LIMIT = 600000;
    localparam int     DRAIN_WAIT  = 100;

    typedef struct {
        logic [11:0] hip;
        logic [11:0] thigh;
        logic [11:0] shin;
        logic        reach;
    } servo_cmd_t;

    logic clk;
    logic rst_n;
    lik_req_if req_ch();
    lik_rsp_if rsp_ch();

    servo_cmd_t pending_cmds[$];
    int         error_count;
    int         cycle_count;
    bit         no_idle;

    leg_inverse_kinematics_servo DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // integer square root, rounded down
    function automatic longint root_floor(longint v);
        longint unsigned r;
        longint unsigned b;
        longint unsigned u;
        r = 0;
        b = 64'd1 << 62;
        u = v;
        while (b > u)
            b >>= 2;
        while (b != 0)
        begin
            if (u >= r + b)
            begin
                u -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return longint'(r);
    endfunction

    // cordic atan2(a, b) in 1/4096 degree
    function automatic longint cordic_angle(longint a, longint b);
        longint px;
        longint py;
        longint ang;
        longint t;
        longint sx;
        longint sy;
        px = b * 256;
        py = a * 256;
        ang = 0;
        if (a == 0 && b == 0)
            return 0;
        if (px < 0)
        begin
            if (py >= 0)
            begin
                t = py; py = -px; px = t; ang = 90 * 4096;
            end
            else
            begin
                t = -py; py = px; px = t; ang = -90 * 4096;
            end
        end
        for (int i = 0; i < CORDIC_ITERS; i++)
        begin
            sx = py >>> i;
            sy = px >>> i;
            if (py > 0)
            begin
                px += sx; py -= sy; ang += longint'(ATAN_TAB[i]);
            end
            else if (py < 0)
            begin
                px -= sx; py += sy; ang -= longint'(ATAN_TAB[i]);
            end
        end
        return ang;
    endfunction

    function automatic longint cos_law_angle(longint n, longint dsq);
        longint r;
        r = dsq - n * n;
        if (r < 0)
            r = 0;
        return cordic_angle(root_floor(r), n);
    endfunction

    function automatic longint q12_to_q4(longint q);
        return (q + 128) >>> 8;
    endfunction

    function automatic logic [11:0] angle_to_pwm(longint a);
        longint c;
        c = (a < 0) ? 0 : ((a > 2880) ? 2880 : a);
        return 12'(PWM_MIN + (c * (PWM_MAX - PWM_MIN)) / 2880);
    endfunction

    function automatic servo_cmd_t solve_leg(logic [2:0] leg, logic signed [15:0] tx,
                                             logic signed [15:0] ty, logic signed [15:0] tz,
                                             logic signed [11:0] ht, logic signed [11:0] tt,
                                             logic signed [11:0] st);
        servo_cmd_t cmd;
        longint x, y, z, l0, l3sq, hip, thigh, shin, gap, span;
        x = tx; y = ty; z = tz;
        gap = SHIN_Q4 - THIGH_Q4;
        span = SHIN_Q4 + THIGH_Q4;
        l0 = root_floor(x * x + y * y) - HIP_Q4;
        l3sq = l0 * l0 + z * z;
        cmd.hip = '0; cmd.thigh = '0; cmd.shin = '0;
        cmd.reach = (l3sq < span * span) && (gap < 0 || l3sq > gap * gap);
        if (!cmd.reach)
            return cmd;
        hip = q12_to_q4(cordic_angle(x, y)) + longint'(ht);
        thigh = q12_to_q4(cos_law_angle(THIGH_Q4 * THIGH_Q4 + l3sq - SHIN_Q4 * SHIN_Q4,
                                        4 * THIGH_Q4 * THIGH_Q4 * l3sq)
                          + cordic_angle(z, l0)) + 104 * 16 + longint'(tt);
        shin = q12_to_q4(cos_law_angle(THIGH_Q4 * THIGH_Q4 + SHIN_Q4 * SHIN_Q4 - l3sq,
                                       4 * THIGH_Q4 * THIGH_Q4 * SHIN_Q4 * SHIN_Q4))
               - 23 * 16 + longint'(st);
        // rear legs wrap the mount offset on the sign of the raw hip angle
        case (leg)
            LEG_0: hip += 45 * 16;
            LEG_1: hip += 90 * 16;
            LEG_2: hip += 135 * 16;
            LEG_3: hip += (hip < 0) ? 225 * 16 : -135 * 16;
            LEG_4: hip += (hip < 0) ? 270 * 16 : -90 * 16;
            LEG_5: hip += (hip < 0) ? 315 * 16 : -45 * 16;
            default: return cmd;
        endcase
        cmd.hip = angle_to_pwm(hip);
        cmd.thigh = angle_to_pwm(thigh);
        cmd.shin = angle_to_pwm(shin);
        return cmd;
    endfunction

    // send one request, then an optional random idle burst
    task automatic send_target(logic [2:0] leg, logic signed [15:0] tx,
                               logic signed [15:0] ty, logic signed [15:0] tz,
                               logic signed [11:0] ht, logic signed [11:0] tt,
                               logic signed [11:0] st);
        req_ch.valid <= 1'b1;
        req_ch.leg_index <= leg;
        req_ch.target_x <= tx;
        req_ch.target_y <= ty;
        req_ch.target_z <= tz;
        req_ch.hip_trim <= ht;
        req_ch.thigh_trim <= tt;
        req_ch.shin_trim <= st;
        do
            @(posedge clk);
        while (!req_ch.ready);
        pending_cmds.push_back(solve_leg(leg, tx, ty, tz, ht, tt, st));
        if (!no_idle && $urandom_range(0, 5) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 15))
                @(posedge clk);
        end
    endtask

    task automatic send_trimless(logic [2:0] leg, logic signed [15:0] tx,
                                 logic signed [15:0] ty, logic signed [15:0] tz);
        send_target(leg, tx, ty, tz, 12'sd0, 12'sd0, 12'sd0);
    endtask

    task automatic wait_drained();
        while (pending_cmds.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_field_extremes();
        send_trimless(3'd0, 16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_trimless(3'd1, 16'sh8000, 16'sh8000, 16'sh8000);
        send_trimless(3'd2, 16'sd0, 16'sd0, 16'sd0);
        send_target(3'd0, 16'sd0, 16'sd1800, 16'sd0, -12'sd1440, -12'sd1440, -12'sd1440);
        send_target(3'd1, 16'sd0, 16'sd1800, 16'sd0, 12'sd1440, 12'sd1440, 12'sd1440);
        send_target(3'd2, 16'sd900, 16'sd1500, -16'sd400, 12'sh800, 12'sh800, 12'sh800);
        send_target(3'd3, -16'sd900, 16'sd1500, 16'sd400, 12'sh7ff, 12'sh7ff, 12'sh7ff);
    endtask

    task automatic test_each_leg();
        // both hip angle signs so rear legs take each wrap branch
        for (int leg = 0; leg < 8; leg++)
        begin
            send_trimless(3'(leg), 16'sd1200, 16'sd1000, -16'sd600);
            send_trimless(3'(leg), -16'sd1200, 16'sd1000, -16'sd600);
        end
    endtask

    task automatic test_reach_boundary();
        // origin in the hip plane: both atan2 operands of the hip are zero
        send_trimless(3'd4, 16'sd0, 16'sd0, 16'sd900);
        send_trimless(3'd5, 16'sd0, 16'sd0, -16'sd2600);
        // just inside and outside the inner and outer reach radius
        send_trimless(3'd0, 16'sd0, 16'sd1281, 16'sd0);
        send_trimless(3'd0, 16'sd0, 16'sd1280, 16'sd0);
        send_trimless(3'd1, 16'sd0, 16'sd3199, 16'sd0);
        send_trimless(3'd1, 16'sd0, 16'sd3200, 16'sd0);
        send_trimless(3'd3, -16'sd1500, -16'sd1500, 16'sd0);
    endtask

    task automatic send_random(bit shaped);
        logic signed [15:0] tx, ty, tz;
        if (shaped)
        begin
            tx = 16'($signed($urandom_range(0, 6400)) - 3200);
            ty = 16'($signed($urandom_range(0, 6400)) - 3200);
            tz = 16'($signed($urandom_range(0, 5400)) - 2700);
        end
        else
        begin
            tx = 16'($urandom);
            ty = 16'($urandom);
            tz = 16'($urandom);
        end
        send_target($urandom_range(0, 9) == 0 ? 3'($urandom_range(6, 7))
                                              : 3'($urandom_range(0, 5)),
                    tx, ty, tz, 12'($urandom), 12'($urandom), 12'($urandom));
    endtask

    task automatic test_random_mix(int count);
        for (int i = 0; i < count; i++)
            send_random($urandom_range(0, 3) != 0);
    endtask

    task automatic test_drain_pause();
        test_random_mix(20);
        req_ch.valid <= 1'b0;
        wait_drained();
        repeat ($urandom_range(1, 15))
            @(posedge clk);
        test_random_mix(20);
    endtask

    task automatic test_full_rate(int count);
        no_idle = 1'b1;
        test_random_mix(count);
    endtask

    // result side stalls in random bursts
    initial
    begin
        rsp_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 40))
                @(posedge clk);
            if (!no_idle)
            begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 15))
                    @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        servo_cmd_t exp_cmd;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_cmds.size() == 0)
            begin
                $display("%0t: result with none expected: hip %0d thigh %0d shin %0d reach %0b",
                         $time, rsp_ch.hip_pwm, rsp_ch.thigh_pwm, rsp_ch.shin_pwm,
                         rsp_ch.reachable);
                error_count++;
            end
            else
            begin
                exp_cmd = pending_cmds.pop_front();
                if (rsp_ch.hip_pwm !== exp_cmd.hip)
                begin
                    $display("%0t: hip_pwm expected %0d actual %0d", $time, exp_cmd.hip,
                             rsp_ch.hip_pwm);
                    error_count++;
                end
                if (rsp_ch.thigh_pwm !== exp_cmd.thigh)
                begin
                    $display("%0t: thigh_pwm expected %0d actual %0d", $time, exp_cmd.thigh,
                             rsp_ch.thigh_pwm);
                    error_count++;
                end
                if (rsp_ch.shin_pwm !== exp_cmd.shin)
                begin
                    $display("%0t: shin_pwm expected %0d actual %0d", $time, exp_cmd.shin,
                             rsp_ch.shin_pwm);
                    error_count++;
                end
                if (rsp_ch.reachable !== exp_cmd.reach)
                begin
                    $display("%0t: reachable expected %0b actual %0b", $time, exp_cmd.reach,
                             rsp_ch.reachable);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("leg_inverse_kinematics_servo verification failed");
            $finish;
        end
    end

    initial
    begin
        error_count = 0;
        cycle_count = 0;
        no_idle = 1'b0;
        rst_n <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.leg_index <= '0;
        req_ch.target_x <= '0;
        req_ch.target_y <= '0;
        req_ch.target_z <= '0;
        req_ch.hip_trim <= '0;
        req_ch.thigh_trim <= '0;
        req_ch.shin_trim <= '0;
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_field_extremes();
        test_each_leg();
        test_reach_boundary();
        test_random_mix(1500);
        test_drain_pause();
        test_full_rate(450);
        req_ch.valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_WAIT)
            @(posedge clk);
        if (error_count == 0 && pending_cmds.size() == 0)
            $display("leg_inverse_kinematics_servo verification clean");
        else
            $display("leg_inverse_kinematics_servo verification failed");
        $finish;
    end
endmodule
